@@ rtl/lease_slot_table_unit_defines.svh @@
// assertion macros for the lease slot table checker
// no dependencies; included by the checker file only
`ifndef LEASE_SLOT_TABLE_UNIT_DEFINES_SVH
`define LEASE_SLOT_TABLE_UNIT_DEFINES_SVH

// same-cycle implication, disabled during reset
`define LST_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled during reset
`define LST_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/lst_pkg.sv @@
// shared types and constants of the lease slot table
// no dependencies; used by the channel interfaces, the top level and the checker
package lst_pkg;

  // default built depth of the slot store
  localparam int POOL_DEPTH_DEF = 256;

  // field widths
  localparam int OP_W     = 2;
  localparam int IP_W     = 32;
  localparam int MAC_W    = 48;
  localparam int START_W  = 8;
  localparam int STATUS_W = 3;
  localparam int SLOT_W   = 8;
  localparam int OCC_W    = 9;

  // configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 32;
  localparam int SIZE_W     = 9;
  localparam logic [CFG_IDX_W-1:0] CFG_POOL_BASE  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_SLOT_LIMIT = 1'b1;
  localparam logic [SIZE_W-1:0]    SLOT_LIMIT_RST = 9'd256;

  // request codes
  localparam logic [OP_W-1:0] OP_ADD    = 2'd0;
  localparam logic [OP_W-1:0] OP_ALLOC  = 2'd1;
  localparam logic [OP_W-1:0] OP_LOOKUP = 2'd2;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_FOUND    = 3'd0;
  localparam logic [STATUS_W-1:0] ST_MOVED    = 3'd1;
  localparam logic [STATUS_W-1:0] ST_REPLACED = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NEW      = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd4;
  localparam logic [STATUS_W-1:0] ST_ERROR    = 3'd5;

endpackage

@@ rtl/lst_channels.sv @@
// valid/ready channel interfaces for requests and results of the slot table
// depends on lst_pkg for field widths
interface lst_req_if;
  import lst_pkg::*;

  logic               valid;
  logic               ready;
  logic [OP_W-1:0]    op;
  logic [IP_W-1:0]    ip;
  logic [MAC_W-1:0]   mac;
  logic [START_W-1:0] start_index;

  modport source (output valid, output op, output ip, output mac, output start_index,
                  input ready);
  modport sink   (input valid, input op, input ip, input mac, input start_index,
                  output ready);
endinterface

interface lst_rsp_if;
  import lst_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [SLOT_W-1:0]   slot;
  logic [OCC_W-1:0]    occupied;

  modport source (output valid, output status, output slot, output occupied,
                  input ready);
  modport sink   (input valid, input status, input slot, input occupied,
                  output ready);
endinterface

@@ rtl/lease_slot_table_unit.sv @@
// lease slot table: address pool slots of {valid, mac} in one synchronous memory
// depends on lst_pkg and the channel interfaces in lst_channels.sv
//
//  channel  | dir | fields                          | handshake
//  ---------+-----+---------------------------------+-------------
//  cfg      | in  | cfg_index, cfg_data             | cfg_we
//  req      | in  | op, ip, mac, start_index        | valid/ready
//  rsp      | out | status, slot, occupied          | valid/ready
//
// after a request is accepted, one memory read per slot scans the whole active range, whose
// length is the active pool size (match, free slot, count); then up to two writes go back
// through the single write port, the second only on a move, and the result is parked in the
// output register before the block returns to idle for the next request.
// after reset a clearing pass writes every entry invalid, with req.ready low throughout.
// a waiting result does not block the next request; only a second finished result waits.
module lease_slot_table_unit #(
  parameter int POOL_DEPTH = lst_pkg::POOL_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [lst_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lst_pkg::CFG_DATA_W-1:0] cfg_data,
  lst_req_if.sink                        req,
  lst_rsp_if.source                      rsp
);
  import lst_pkg::*;

  localparam int IDXW  = $clog2(POOL_DEPTH);
  localparam int CNTW  = $clog2(POOL_DEPTH + 1);
  localparam int ENTW  = MAC_W + 1;

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_SCAN   = 3'd2;
  localparam logic [2:0] S_DECIDE = 3'd3;
  localparam logic [2:0] S_WR2    = 3'd4;
  localparam logic [2:0] S_DONE   = 3'd5;

  // configuration registers
  logic [IP_W-1:0]   pool_base;
  logic [SIZE_W-1:0] slot_limit;

  always_ff @(posedge clk) begin
    if (rst) begin
      pool_base  <= '0;
      slot_limit <= SLOT_LIMIT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_POOL_BASE:  pool_base  <= cfg_data;
        CFG_SLOT_LIMIT: slot_limit <= cfg_data[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  // active size, clamped to the built depth
  logic [CNTW-1:0] n_cur;
  assign n_cur = (32'(slot_limit) > POOL_DEPTH) ? CNTW'(POOL_DEPTH) : CNTW'(slot_limit);

  // add address offset into the pool
  logic [IP_W-1:0] offset;
  assign offset = req.ip - pool_base;

  // control
  logic [2:0]      state;
  logic [CNTW-1:0] cnt;
  logic            rd_pend;
  logic [IDXW-1:0] rd_idx;

  // request held for the duration of the scan
  logic [OP_W-1:0]    op_q;
  logic [MAC_W-1:0]   mac_q;
  logic [START_W-1:0] start_q;
  logic [IDXW-1:0]    idx_q;
  logic               range_ok;
  logic [CNTW-1:0]    n_q;

  // scan results
  logic            match_found;
  logic [IDXW-1:0] match_idx;
  logic            free_found;
  logic [IDXW-1:0] free_idx;
  logic            idx_valid;
  logic [CNTW-1:0] count;

  // finished result waiting for the output register
  logic [STATUS_W-1:0] res_status;
  logic [IDXW-1:0]     res_slot;
  logic [CNTW-1:0]     res_count;

  // memory ports
  logic [ENTW-1:0] mem [POOL_DEPTH];
  logic            wr_en;
  logic [IDXW-1:0] wr_addr;
  logic [ENTW-1:0] wr_data;
  logic            rd_en;
  logic [ENTW-1:0] rd_data;

  logic accept;
  assign req.ready = (state == S_IDLE);
  assign accept    = req.valid && req.ready;

  // slot store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[cnt[IDXW-1:0]];
    end
  end

  assign rd_en = (state == S_SCAN) && (cnt < n_q);

  // decision on the finished scan
  logic                is_move;
  logic                dec_we;
  logic [IDXW-1:0]     dec_addr;
  logic [STATUS_W-1:0] dec_status;
  logic [IDXW-1:0]     dec_slot;
  logic [CNTW-1:0]     dec_count;

  always_comb begin
    is_move    = 1'b0;
    dec_we     = 1'b0;
    dec_addr   = idx_q;
    dec_status = ST_ERROR;
    dec_slot   = '0;
    dec_count  = count;
    case (op_q)
      OP_ADD: begin
        if (range_ok) begin
          dec_slot = idx_q;
          if (match_found) begin
            if (match_idx == idx_q) begin
              dec_status = ST_FOUND;
            end else begin
              dec_status = ST_MOVED;
              dec_we     = 1'b1;
              is_move    = 1'b1;
              // old slot cleared; address slot gains only if it was empty
              dec_count  = idx_valid ? count - CNTW'(1) : count;
            end
          end else if (idx_valid) begin
            dec_status = ST_REPLACED;
            dec_we     = 1'b1;
          end else begin
            dec_status = ST_NEW;
            dec_we     = 1'b1;
            dec_count  = count + CNTW'(1);
          end
        end
      end
      OP_ALLOC: begin
        if (free_found) begin
          dec_status = ST_NEW;
          dec_slot   = free_idx;
          dec_addr   = free_idx;
          dec_we     = 1'b1;
          dec_count  = count + CNTW'(1);
        end
      end
      OP_LOOKUP: begin
        if (match_found) begin
          dec_status = ST_FOUND;
          dec_slot   = match_idx;
        end else begin
          dec_status = ST_NOTFOUND;
        end
      end
      default: ;
    endcase
  end

  // write port mux
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = cnt[IDXW-1:0];
    wr_data = '0;
    unique case (state)
      S_CLEAR: begin
        wr_en = 1'b1;
      end
      S_DECIDE: begin
        wr_en   = dec_we;
        wr_addr = dec_addr;
        wr_data = {1'b1, mac_q};
      end
      S_WR2: begin
        wr_en   = 1'b1;
        wr_addr = match_idx;
      end
      default: ;
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      cnt     <= '0;
      rd_pend <= 1'b0;
    end else begin
      rd_pend <= rd_en;
      unique case (state)
        S_CLEAR: begin
          if (cnt == CNTW'(POOL_DEPTH - 1)) begin
            state <= S_IDLE;
            cnt   <= '0;
          end else begin
            cnt <= cnt + CNTW'(1);
          end
        end
        S_IDLE: begin
          if (accept) begin
            state <= S_SCAN;
            cnt   <= '0;
          end
        end
        S_SCAN: begin
          if (rd_en) begin
            cnt <= cnt + CNTW'(1);
          end else if (!rd_pend) begin
            state <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          state <= is_move ? S_WR2 : S_DONE;
        end
        S_WR2: begin
          state <= S_DONE;
        end
        S_DONE: begin
          if (!rsp.valid || rsp.ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_CLEAR;
      endcase
    end
  end

  // request capture
  always_ff @(posedge clk) begin
    if (accept) begin
      op_q     <= req.op;
      mac_q    <= req.mac;
      start_q  <= req.start_index;
      idx_q    <= offset[IDXW-1:0];
      range_ok <= (offset < 32'(n_cur));
      n_q      <= n_cur;
    end
  end

  // scan accumulation, one slot per beat of read data
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_idx <= cnt[IDXW-1:0];
    end
    if (accept) begin
      match_found <= 1'b0;
      match_idx   <= '0;
      free_found  <= 1'b0;
      free_idx    <= '0;
      idx_valid   <= 1'b0;
      count       <= '0;
    end else if (state == S_SCAN && rd_pend) begin
      if (rd_data[MAC_W]) begin
        count <= count + CNTW'(1);
        if (!match_found && rd_data[MAC_W-1:0] == mac_q) begin
          match_found <= 1'b1;
          match_idx   <= rd_idx;
        end
      end else if (!free_found && 32'(rd_idx) >= 32'(start_q)) begin
        free_found <= 1'b1;
        free_idx   <= rd_idx;
      end
      if (rd_idx == idx_q) begin
        idx_valid <= rd_data[MAC_W];
      end
    end
  end

  // finished result
  always_ff @(posedge clk) begin
    if (state == S_DECIDE) begin
      res_status <= dec_status;
      res_slot   <= dec_slot;
      res_count  <= dec_count;
    end
  end

  // output register
  logic load_out;
  assign load_out = (state == S_DONE) && (!rsp.valid || rsp.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (load_out) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      rsp.status   <= res_status;
      rsp.slot     <= SLOT_W'(res_slot);
      rsp.occupied <= OCC_W'(res_count);
    end
  end

endmodule

@@ rtl/lst_checker.sv @@
// port-level checks of the lease slot table, bound to the top level
// depends on lst_pkg and lease_slot_table_unit_defines.svh
`include "lease_slot_table_unit_defines.svh"

module lst_checker #(
  parameter int POOL_DEPTH = lst_pkg::POOL_DEPTH_DEF
) (
  input logic                         clk,
  input logic                         rst,
  input logic                         req_ready,
  input logic                         rsp_valid,
  input logic                         rsp_ready,
  input logic [lst_pkg::STATUS_W-1:0] rsp_status,
  input logic [lst_pkg::SLOT_W-1:0]   rsp_slot,
  input logic [lst_pkg::OCC_W-1:0]    rsp_occupied
);
  import lst_pkg::*;

  // a stalled result beat stays offered
  `LST_ASSERT_NEXT(a_rsp_hold, clk, rst, rsp_valid && !rsp_ready, rsp_valid, "result beat dropped while stalled")

  // only defined status codes, and a count within the built depth
  `LST_ASSERT_NOW(a_status_range, clk, rst, rsp_valid, rsp_status <= ST_ERROR && 32'(rsp_occupied) <= POOL_DEPTH, "result out of range")

  // errors and misses report slot zero
  `LST_ASSERT_NOW(a_slot_zero, clk, rst, rsp_valid && (rsp_status == ST_ERROR || rsp_status == ST_NOTFOUND), rsp_slot == '0, "nonzero slot on miss or error")

  // the clearing pass holds off requests and results right after reset
  `LST_ASSERT_NOW(a_clear_pass, clk, rst, $past(rst), !req_ready && !rsp_valid, "block active during clearing pass")

endmodule

bind lease_slot_table_unit lst_checker #(.POOL_DEPTH(POOL_DEPTH)) u_lst_checker (
  .clk          (clk),
  .rst          (rst),
  .req_ready    (req.ready),
  .rsp_valid    (rsp.valid),
  .rsp_ready    (rsp.ready),
  .rsp_status   (rsp.status),
  .rsp_slot     (rsp.slot),
  .rsp_occupied (rsp.occupied)
);
